// ===== rtl/szc_pkg.sv =====
package szc_pkg;

  // Plane distance at scale 2^-32, and its difference
  localparam int DW  = 54;
  localparam int EW  = 55;
  // Exact crossing-side numerator
  localparam int ACW = 110;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_IW-1:0] CFG_ZONE_IS_SPHERE  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SPHERE_CENTER_X = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SPHERE_CENTER_Y = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SPHERE_CENTER_Z = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_SPHERE_RADIUS   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_PLANE_COUNT     = 3'd5;

  localparam logic [4:0] PLANE_COUNT_RST = 5'd6;

  typedef struct packed {
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
    logic signed [31:0] off;
  } plane_t;

  typedef struct packed {
    logic signed [DW-1:0] sa;
    logic signed [DW-1:0] sb;
  } dist_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_WPLANE,
    DP_LOAD,
    DP_SQ,
    DP_SPH_EVAL,
    DP_HREAD,
    DP_DMUL,
    DP_DWRITE,
    DP_DREAD,
    DP_LATI,
    DP_STOP,
    DP_CROSS,
    DP_LD1,
    DP_LD2,
    DP_MSTEP,
    DP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] k;
    logic       fin;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic sphere;
    logic both_nonneg;
    logic strict;
    logic mul_done;
    logic cross_out;
  } sts_t;

endpackage

// ===== rtl/szc_if.sv =====
interface szc_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [3:0]         plane_slot;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic signed [17:0] normal_z;
  logic signed [31:0] plane_offset;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;

  modport source (
    output valid, req_type, plane_slot, normal_x, normal_y, normal_z, plane_offset,
           start_x, start_y, start_z, end_x, end_y, end_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, plane_slot, normal_x, normal_y, normal_z, plane_offset,
           start_x, start_y, start_z, end_x, end_y, end_z,
    output ready
  );
endinterface

interface szc_out_if;
  logic valid;
  logic ready;
  logic entered;
  logic exited;
  logic stayed_inside;
  logic touched;

  modport source (output valid, entered, exited, stayed_inside, touched, input ready);
  modport sink (input valid, entered, exited, stayed_inside, touched, output ready);
endinterface

// ===== rtl/szc_dp.sv =====
module szc_dp #(
  parameter int MAX_PLANES = 16,
  parameter int AW = 4,
  parameter int NW = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [szc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [szc_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic [3:0]                 plane_slot,
  input  logic signed [17:0]         normal_x,
  input  logic signed [17:0]         normal_y,
  input  logic signed [17:0]         normal_z,
  input  logic signed [31:0]         plane_offset,
  input  logic signed [31:0]         start_x,
  input  logic signed [31:0]         start_y,
  input  logic signed [31:0]         start_z,
  input  logic signed [31:0]         end_x,
  input  logic signed [31:0]         end_y,
  input  logic signed [31:0]         end_z,
  input  szc_pkg::cmd_t              cmd,
  input  logic [AW-1:0]              addr,
  output szc_pkg::sts_t              sts,
  output logic [NW-1:0]              n_planes,
  output logic                       entered,
  output logic                       exited,
  output logic                       stayed_inside,
  output logic                       touched
);
  import szc_pkg::*;

  typedef enum logic [2:0] {T_NONE, T_DA, T_DB, T_SS, T_SE, T_R2} tag_t;

  // configuration registers
  logic               sphere_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0]        radius_r;
  logic [4:0]         count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sphere_r <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
      radius_r <= '0;
      count_r  <= PLANE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZONE_IS_SPHERE:  sphere_r <= cfg_wdata[0];
        CFG_SPHERE_CENTER_X: cx_r     <= cfg_wdata;
        CFG_SPHERE_CENTER_Y: cy_r     <= cfg_wdata;
        CFG_SPHERE_CENTER_Z: cz_r     <= cfg_wdata;
        CFG_SPHERE_RADIUS:   radius_r <= cfg_wdata[30:0];
        CFG_PLANE_COUNT:     count_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // planes in use, clipped to storage
  assign n_planes = (8'(count_r) > 8'(MAX_PLANES)) ? NW'(MAX_PLANES) : NW'(count_r);

  // hull plane store
  plane_t hm [MAX_PLANES];
  plane_t hrd_r;
  logic   slot_ok;

  assign slot_ok = 8'(plane_slot) < 8'(MAX_PLANES);

  always_ff @(posedge clk) begin
    if (cmd.op == DP_WPLANE && slot_ok) begin
      hm[AW'(plane_slot)] <= '{nx: normal_x, ny: normal_y, nz: normal_z, off: plane_offset};
    end
    if (cmd.op == DP_HREAD) begin
      hrd_r <= hm[addr];
    end
  end

  // segment end points
  logic signed [31:0] sx_r, sy_r, sz_r, ex_r, ey_r, ez_r;

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      sx_r <= start_x;
      sy_r <= start_y;
      sz_r <= start_z;
      ex_r <= end_x;
      ey_r <= end_y;
      ez_r <= end_z;
    end
  end

  // operand select for the shared multiplier
  logic signed [31:0] pt;
  logic signed [31:0] cen;
  logic signed [17:0] nrm;
  logic signed [32:0] d33;
  logic [32:0]        dmag;
  logic               dbig;
  logic signed [32:0] ma, mb;
  tag_t               tag_nxt;

  always_comb begin
    pt  = sx_r;
    cen = cx_r;
    nrm = hrd_r.nx;
    case (cmd.k)
      3'd0: begin pt = sx_r; cen = cx_r; nrm = hrd_r.nx; end
      3'd1: begin pt = (cmd.op == DP_SQ) ? sx_r : sy_r; cen = cx_r; nrm = hrd_r.ny; end
      3'd2: begin pt = (cmd.op == DP_SQ) ? sy_r : sz_r; cen = cy_r; nrm = hrd_r.nz; end
      3'd3: begin pt = (cmd.op == DP_SQ) ? sz_r : ex_r; cen = cz_r; nrm = hrd_r.nx; end
      3'd4: begin pt = ex_r; cen = cx_r; nrm = hrd_r.ny; end
      3'd5: begin pt = (cmd.op == DP_SQ) ? ey_r : ez_r; cen = cy_r; nrm = hrd_r.nz; end
      3'd6: begin pt = ez_r; cen = cz_r; nrm = hrd_r.nz; end
      default: ;
    endcase
    // dmul: k4 is end y
    if (cmd.op == DP_DMUL && cmd.k == 3'd4) begin
      pt = ey_r;
    end
  end

  assign d33  = {pt[31], pt} - {cen[31], cen};
  assign dmag = d33[32] ? 33'(-d33) : 33'(d33);
  assign dbig = |dmag[32:31];

  always_comb begin
    ma      = '0;
    mb      = '0;
    tag_nxt = T_NONE;
    case (cmd.op)
      DP_SQ: begin
        if (cmd.k == 3'd0) begin
          ma      = {2'b00, radius_r};
          mb      = {2'b00, radius_r};
          tag_nxt = T_R2;
        end else begin
          ma      = d33;
          mb      = d33;
          tag_nxt = (cmd.k < 3'd4) ? T_SS : T_SE;
        end
      end
      DP_DMUL: begin
        ma      = {pt[31], pt};
        mb      = {{15{nrm[17]}}, nrm};
        tag_nxt = (cmd.k < 3'd3) ? T_DA : T_DB;
      end
      default: ;
    endcase
  end

  // product register and accumulators
  logic signed [65:0]   p_r;
  tag_t                 tag_r;
  logic signed [DW-1:0] da_r, db_r;
  logic [63:0]          sum_s_r, sum_e_r;
  logic [61:0]          r2_r;
  logic                 big_s_r, big_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= T_NONE;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= ma * mb;
    if (cmd.op == DP_SQ && cmd.k == 3'd0) begin
      sum_s_r <= '0;
      sum_e_r <= '0;
      big_s_r <= 1'b0;
      big_e_r <= 1'b0;
    end else if (cmd.op == DP_SQ && cmd.k < 3'd4) begin
      big_s_r <= big_s_r | dbig;
    end else if (cmd.op == DP_SQ) begin
      big_e_r <= big_e_r | dbig;
    end
    if (cmd.op == DP_DMUL && cmd.k == 3'd0) begin
      da_r <= {{6{hrd_r.off[31]}}, hrd_r.off, 16'b0};
      db_r <= {{6{hrd_r.off[31]}}, hrd_r.off, 16'b0};
    end
    case (tag_r)
      T_DA: da_r <= da_r + p_r[DW-1:0];
      T_DB: db_r <= db_r + p_r[DW-1:0];
      T_SS: sum_s_r <= sum_s_r + p_r[63:0];
      T_SE: sum_e_r <= sum_e_r + p_r[63:0];
      T_R2: r2_r <= p_r[61:0];
      default: ;
    endcase
  end

  // per-plane distance store
  dist_t dm [MAX_PLANES];
  dist_t drd_r;

  always_ff @(posedge clk) begin
    if (cmd.op == DP_DWRITE) begin
      dm[addr] <= '{sa: da_r, sb: db_r};
    end
    if (cmd.op == DP_DREAD) begin
      drd_r <= dm[addr];
    end
  end

  // current plane and crossing test
  logic signed [DW-1:0]  a_r, b_r;
  logic signed [EW-1:0]  den, diff_j, a_ext;
  logic [EW-1:0]         den_mag, a_mag;
  logic signed [ACW-1:0] sa_ext, diff_ext;
  logic signed [ACW-1:0] acc_r, mcand_r;
  logic [EW-1:0]         mplier_r;

  assign den      = {a_r[DW-1], a_r} - {b_r[DW-1], b_r};
  assign den_mag  = den[EW-1] ? EW'(-den) : EW'(den);
  assign a_ext    = {a_r[DW-1], a_r};
  assign a_mag    = a_ext[EW-1] ? EW'(-a_ext) : EW'(a_ext);
  assign diff_j   = {drd_r.sb[DW-1], drd_r.sb} - {drd_r.sa[DW-1], drd_r.sa};
  assign sa_ext   = ACW'(drd_r.sa);
  assign diff_ext = ACW'(diff_j);

  // shift-add multiply, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATI: begin
        a_r <= drd_r.sa;
        b_r <= drd_r.sb;
      end
      DP_LD1: begin
        acc_r    <= '0;
        mplier_r <= den_mag;
        mcand_r  <= den[EW-1] ? -sa_ext : sa_ext;
      end
      DP_LD2: begin
        mplier_r <= a_mag;
        mcand_r  <= a_r[DW-1] ? -diff_ext : diff_ext;
      end
      DP_MSTEP: begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r <<< 1;
        mplier_r <= mplier_r >> 1;
      end
      default: ;
    endcase
  end

  // result flags
  logic ent_r, ext_r, stay_r, cross_r, stop_r;
  logic in_s, in_e;

  assign in_s = !big_s_r && (sum_s_r < {2'b00, r2_r});
  assign in_e = !big_e_r && (sum_e_r < {2'b00, r2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r   <= 1'b0;
      ext_r   <= 1'b0;
      stay_r  <= 1'b0;
      cross_r <= 1'b0;
      stop_r  <= 1'b0;
    end else begin
      case (cmd.op)
        DP_LOAD: begin
          ent_r   <= 1'b0;
          ext_r   <= 1'b0;
          stay_r  <= 1'b0;
          cross_r <= 1'b0;
          stop_r  <= 1'b0;
        end
        DP_SPH_EVAL: begin
          ent_r  <= !in_s && in_e;
          ext_r  <= in_s && !in_e;
          stay_r <= in_s && in_e;
        end
        DP_STOP:   stop_r  <= 1'b1;
        DP_CROSS:  cross_r <= 1'b1;
        DP_COMMIT: begin
          if (a_r[DW-1]) begin
            ext_r <= 1'b1;
          end else begin
            ent_r <= 1'b1;
          end
        end
        default: ;
      endcase
      if (cmd.fin) begin
        stay_r <= !stop_r && !cross_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      entered       <= ent_r;
      exited        <= ext_r;
      stayed_inside <= stay_r;
      touched       <= ent_r | ext_r | stay_r;
    end
  end

  assign sts.sphere      = sphere_r;
  assign sts.both_nonneg = !a_r[DW-1] && !b_r[DW-1];
  assign sts.strict      = (a_r > 0 && b_r < 0) || (a_r < 0 && b_r > 0);
  assign sts.mul_done    = (mplier_r == '0);
  assign sts.cross_out   = (acc_r != '0) && (acc_r[ACW-1] == den[EW-1]);

endmodule

// ===== rtl/szc_ctrl.sv =====
module szc_ctrl #(
  parameter int MAX_PLANES = 16,
  parameter int AW = 4,
  parameter int NW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  szc_pkg::sts_t sts,
  input  logic [NW-1:0] n_planes,
  output szc_pkg::cmd_t cmd,
  output logic [AW-1:0] addr
);
  import szc_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_DIST = 14'b00000000000010,
    S_WRD  = 14'b00000000000100,
    S_WLAT = 14'b00000000001000,
    S_WDEC = 14'b00000000010000,
    S_CRD  = 14'b00000000100000,
    S_CLD1 = 14'b00000001000000,
    S_CM1  = 14'b00000010000000,
    S_CLD2 = 14'b00000100000000,
    S_CM2  = 14'b00001000000000,
    S_CEV  = 14'b00010000000000,
    S_SPH  = 14'b00100000000000,
    S_FIN  = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  localparam logic [3:0] STEP_WAIT = 4'd7;
  localparam logic [3:0] STEP_LAST = 4'd8;

  state_t        state_r, state_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [NW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cmd       = '{op: DP_NOP, k: 3'd0, fin: 1'b0, emit: 1'b0};
    addr      = i_r[AW-1:0];
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        step_nxt = '0;
        i_nxt    = '0;
        if (in_valid) begin
          if (!in_req) begin
            cmd.op = DP_WPLANE;
          end else begin
            cmd.op    = DP_LOAD;
            state_nxt = sts.sphere ? S_SPH : S_DIST;
          end
        end
      end
      // six products per plane, then store the pair
      S_DIST: begin
        if (i_r >= n_planes) begin
          i_nxt     = '0;
          state_nxt = S_WRD;
        end else begin
          step_nxt = step_r + 4'd1;
          if (step_r == 4'd0) begin
            cmd.op = DP_HREAD;
          end else if (step_r < STEP_WAIT) begin
            cmd.op = DP_DMUL;
            cmd.k  = 3'(step_r - 4'd1);
          end else if (step_r == STEP_LAST) begin
            cmd.op   = DP_DWRITE;
            step_nxt = '0;
            i_nxt    = i_r + 1'b1;
          end
        end
      end
      S_WRD: begin
        if (i_r >= n_planes) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op    = DP_DREAD;
          state_nxt = S_WLAT;
        end
      end
      S_WLAT: begin
        cmd.op    = DP_LATI;
        state_nxt = S_WDEC;
      end
      S_WDEC: begin
        if (sts.both_nonneg) begin
          cmd.op    = DP_STOP;
          state_nxt = S_FIN;
        end else if (sts.strict) begin
          cmd.op    = DP_CROSS;
          j_nxt     = '0;
          state_nxt = S_CRD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_WRD;
        end
      end
      // crossing point against every other plane, until one puts it outside
      S_CRD: begin
        addr = j_r[AW-1:0];
        if (j_r >= n_planes) begin
          cmd.op    = DP_COMMIT;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_WRD;
        end else if (j_r == i_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          cmd.op    = DP_DREAD;
          state_nxt = S_CLD1;
        end
      end
      S_CLD1: begin
        cmd.op    = DP_LD1;
        state_nxt = S_CM1;
      end
      S_CM1: begin
        if (sts.mul_done) begin
          state_nxt = S_CLD2;
        end else begin
          cmd.op = DP_MSTEP;
        end
      end
      S_CLD2: begin
        cmd.op    = DP_LD2;
        state_nxt = S_CM2;
      end
      S_CM2: begin
        if (sts.mul_done) begin
          state_nxt = S_CEV;
        end else begin
          cmd.op = DP_MSTEP;
        end
      end
      S_CEV: begin
        if (sts.cross_out) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_WRD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_CRD;
        end
      end
      // radius square, then both ends' squared distances
      S_SPH: begin
        step_nxt = step_r + 4'd1;
        if (step_r < STEP_WAIT) begin
          cmd.op = DP_SQ;
          cmd.k  = 3'(step_r);
        end else if (step_r == STEP_LAST) begin
          cmd.op    = DP_SPH_EVAL;
          state_nxt = S_DONE;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid: set on emit, cleared on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/segment_zone_crossing_classifier_unit.sv =====
// Classifies a segment from start to end against a sphere or a convex hull
// of planes and returns entered, exited, stayed_inside and touched; a plane
// write returns nothing. One item is worked on at a time.
// A sphere classify runs seven squares through one 33x33 multiplier. A
// hull classify first computes both end distances of each plane (six
// products on the same multiplier), then walks the planes; each plane with
// a strict sign change is tested against the other planes, each by two
// shift-add multiplies that retire one multiplier bit per cycle and end
// early when the bits run out, until one puts the crossing outside.
// A finished result is held in an output register, so the next item can be
// accepted while it waits.
module segment_zone_crossing_classifier_unit #(
  parameter int MAX_PLANES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  szc_in_if.sink                     in_if,
  szc_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic [szc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [szc_pkg::CFG_DW-1:0] cfg_wdata
);
  import szc_pkg::*;

  localparam int AW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int NW = $clog2(MAX_PLANES + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] addr;
  logic [NW-1:0] n_planes;

  szc_ctrl #(.MAX_PLANES(MAX_PLANES), .AW(AW), .NW(NW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_req    (in_if.req_type),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .sts       (sts),
    .n_planes  (n_planes),
    .cmd       (cmd),
    .addr      (addr)
  );

  szc_dp #(.MAX_PLANES(MAX_PLANES), .AW(AW), .NW(NW)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .plane_slot    (in_if.plane_slot),
    .normal_x      (in_if.normal_x),
    .normal_y      (in_if.normal_y),
    .normal_z      (in_if.normal_z),
    .plane_offset  (in_if.plane_offset),
    .start_x       (in_if.start_x),
    .start_y       (in_if.start_y),
    .start_z       (in_if.start_z),
    .end_x         (in_if.end_x),
    .end_y         (in_if.end_y),
    .end_z         (in_if.end_z),
    .cmd           (cmd),
    .addr          (addr),
    .sts           (sts),
    .n_planes      (n_planes),
    .entered       (out_if.entered),
    .exited        (out_if.exited),
    .stayed_inside (out_if.stayed_inside),
    .touched       (out_if.touched)
  );

  // a new result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_if.valid || out_if.ready))
    else $error("result emitted over a pending result");

  // plane writes and loads happen only on an input transfer
  a_load_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_WPLANE || cmd.op == DP_LOAD) |-> (in_if.valid && in_if.ready))
    else $error("datapath load without input transfer");

  // staying inside excludes any crossing
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.stayed_inside && (out_if.entered || out_if.exited)))
    else $error("stayed_inside together with a crossing");

  // touched follows the other flags
  a_touch: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.touched ==
                      (out_if.entered || out_if.exited || out_if.stayed_inside)))
    else $error("touched does not match flags");

endmodule

// ===== test/segment_zone_crossing_classifier_unit_test.sv =====
`timescale 1ns / 1ps

// Crossing flags of one classify result
typedef struct packed {
  logic entered;
  logic exited;
  logic stayed_inside;
  logic touched;
} zone_flags_t;

// Tracks zone configuration and hull planes, predicts flags, checks results
class zone_scoreboard;
  bit              is_sphere;
  longint          cx, cy, cz;
  longint          radius;
  int unsigned     count;
  longint          pnx[16], pny[16], pnz[16], poff[16];
  bit              written[16];
  zone_flags_t     pending[$];
  int              errors;
  int              n_results;

  function new();
    is_sphere = 0; cx = 0; cy = 0; cz = 0; radius = 0; count = 6;
    errors = 0; n_results = 0;
    foreach (written[k]) begin
      written[k] = 0; pnx[k] = 0; pny[k] = 0; pnz[k] = 0; poff[k] = 0;
    end
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      szc_pkg::CFG_ZONE_IS_SPHERE:  is_sphere = v[0];
      szc_pkg::CFG_SPHERE_CENTER_X: cx = longint'($signed(v));
      szc_pkg::CFG_SPHERE_CENTER_Y: cy = longint'($signed(v));
      szc_pkg::CFG_SPHERE_CENTER_Z: cz = longint'($signed(v));
      szc_pkg::CFG_SPHERE_RADIUS:   radius = longint'({1'b0, v[30:0]});
      szc_pkg::CFG_PLANE_COUNT:     count = v[4:0];
      default: ;
    endcase
  endfunction

  function bit point_in_sphere(longint x, longint y, longint z);
    longint dx, dy, dz;
    logic [127:0] acc;
    dx = x - cx; dy = y - cy; dz = z - cz;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    if (dx >= 64'sd2147483648 || dy >= 64'sd2147483648 || dz >= 64'sd2147483648)
      return 0;
    acc = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
    return acc < 128'(radius) * 128'(radius);
  endfunction

  function longint plane_dist(int k, longint x, longint y, longint z);
    return x * pnx[k] + y * pny[k] + z * pnz[k] + poff[k] * 65536;
  endfunction

  // Note an accepted input; classify requests queue their expected flags
  function void note_request(logic rt, logic [3:0] slot, logic [17:0] nx, logic [17:0] ny,
                             logic [17:0] nz, logic [31:0] off, logic [31:0] s[3],
                             logic [31:0] e[3]);
    zone_flags_t f;
    longint sa[16], sb[16], px, py, pz, qx, qy, qz, a, b, den;
    int unsigned n, clear;
    bit stopped, outside;
    logic signed [127:0] num;
    if (!rt) begin
      pnx[slot] = longint'($signed(nx)); pny[slot] = longint'($signed(ny));
      pnz[slot] = longint'($signed(nz)); poff[slot] = longint'($signed(off));
      written[slot] = 1;
      return;
    end
    f = '0;
    px = longint'($signed(s[0])); py = longint'($signed(s[1]));
    pz = longint'($signed(s[2]));
    qx = longint'($signed(e[0])); qy = longint'($signed(e[1]));
    qz = longint'($signed(e[2]));
    if (is_sphere) begin
      a = point_in_sphere(px, py, pz);
      b = point_in_sphere(qx, qy, qz);
      f.entered = !a && b;
      f.exited = a && !b;
      f.stayed_inside = a && b;
    end else begin
      n = count > 16 ? 16 : count;
      clear = 0; stopped = 0;
      for (int i = 0; i < n; i++) begin
        sa[i] = plane_dist(i, px, py, pz);
        sb[i] = plane_dist(i, qx, qy, qz);
      end
      for (int i = 0; i < n; i++) begin
        a = sa[i]; b = sb[i];
        if (a >= 0 && b >= 0) begin
          stopped = 1;
          break;
        end
        if ((a > 0 && b < 0) || (a < 0 && b > 0)) begin
          den = a - b;
          outside = 0;
          for (int j = 0; j < n && !outside; j++) begin
            if (j == i) continue;
            num = 128'(signed'(sa[j])) * 128'(signed'(den))
                + 128'(signed'(a)) * 128'(signed'(sb[j] - sa[j]));
            if (num != 0 && ((num < 0) == (den < 0))) outside = 1;
          end
          if (!outside) begin
            if (a < 0) f.exited = 1;
            else f.entered = 1;
          end
        end else begin
          clear++;
        end
      end
      if (!stopped && clear == n) f.stayed_inside = 1;
    end
    f.touched = f.entered | f.exited | f.stayed_inside;
    pending.push_back(f);
  endfunction

  function void check_result(zone_flags_t got);
    zone_flags_t want;
    n_results++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %b", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (want.entered != got.entered)
      $display("%0t: entered expected %b actual %b", $time, want.entered, got.entered);
    if (want.exited != got.exited)
      $display("%0t: exited expected %b actual %b", $time, want.exited, got.exited);
    if (want.stayed_inside != got.stayed_inside)
      $display("%0t: stayed_inside expected %b actual %b", $time, want.stayed_inside,
               got.stayed_inside);
    if (want.touched != got.touched)
      $display("%0t: touched expected %b actual %b", $time, want.touched, got.touched);
    if (want != got) errors++;
  endfunction
endclass

module segment_zone_crossing_classifier_unit_test;
  import szc_pkg::*;

  localparam longint CYCLE_LIMIT = 64'd100000000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  longint cycles = 0;
  int n_inputs = 0;
  zone_scoreboard zone_sb;

  szc_in_if  seg_ch ();
  szc_out_if flag_ch ();

  segment_zone_crossing_classifier_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_if(seg_ch.sink), .out_if(flag_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    seg_ch.valid = 0; seg_ch.req_type = 0; seg_ch.plane_slot = 0;
    seg_ch.normal_x = 0; seg_ch.normal_y = 0; seg_ch.normal_z = 0;
    seg_ch.plane_offset = 0; seg_ch.start_x = 0; seg_ch.start_y = 0;
    seg_ch.start_z = 0; seg_ch.end_x = 0; seg_ch.end_y = 0; seg_ch.end_z = 0;
    flag_ch.ready = 0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: stalls on its own pattern, checks each result transfer
  int stall_mode = 0;
  always @(posedge clk) begin
    if (flag_ch.valid && flag_ch.ready)
      zone_sb.check_result({flag_ch.entered, flag_ch.exited, flag_ch.stayed_inside,
                            flag_ch.touched});
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: flag_ch.ready <= 1'b1;
      1: flag_ch.ready <= ($urandom_range(0, 3) != 0);
      2: flag_ch.ready <= ($urandom_range(0, 3) == 0);
      default: flag_ch.ready <= cycles[2];
    endcase
  end

  // Sender: note each input transfer with the scoreboard
  always @(posedge clk) begin
    if (rst_n && seg_ch.valid && seg_ch.ready) begin
      zone_sb.note_request(seg_ch.req_type, seg_ch.plane_slot, seg_ch.normal_x,
                           seg_ch.normal_y, seg_ch.normal_z, seg_ch.plane_offset,
                           '{seg_ch.start_x, seg_ch.start_y, seg_ch.start_z},
                           '{seg_ch.end_x, seg_ch.end_y, seg_ch.end_z});
      n_inputs <= n_inputs + 1;
    end
  end

  int burst_left = 0;

  // Drive one item and hold until transferred; gaps between bursts
  task automatic send_item(logic rt, logic [3:0] slot, logic [17:0] nx, logic [17:0] ny,
                           logic [17:0] nz, logic [31:0] off, logic [31:0] sx,
                           logic [31:0] sy, logic [31:0] sz, logic [31:0] ex,
                           logic [31:0] ey, logic [31:0] ez);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) begin
        seg_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    burst_left--;
    seg_ch.valid <= 1'b1; seg_ch.req_type <= rt; seg_ch.plane_slot <= slot;
    seg_ch.normal_x <= nx; seg_ch.normal_y <= ny; seg_ch.normal_z <= nz;
    seg_ch.plane_offset <= off; seg_ch.start_x <= sx; seg_ch.start_y <= sy;
    seg_ch.start_z <= sz; seg_ch.end_x <= ex; seg_ch.end_y <= ey; seg_ch.end_z <= ez;
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
  endtask

  task automatic idle_sender();
    seg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    zone_sb.set_reg(idx, v);
  endtask

  // Wait for all results, then let a trailing plane write settle
  task automatic drain();
    idle_sender();
    while (zone_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic logic [17:0] rand_normal();
    case ($urandom_range(0, 4))
      0: return 18'($urandom);
      1: return $urandom_range(0, 1) ? 18'h1ffff : 18'h20000;
      default: return 18'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
    endcase
  endfunction

  task automatic send_plane(logic [3:0] slot, logic [17:0] nx, logic [17:0] ny,
                            logic [17:0] nz, logic [31:0] off);
    send_item(1'b0, slot, nx, ny, nz, off, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
  endtask

  task automatic send_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                              logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
    send_item(1'b1, 4'($urandom), rand_normal(), rand_normal(), rand_normal(),
              $urandom, sx, sy, sz, ex, ey, ez);
  endtask

  // Axis-aligned box hull in slots 0..5, half size h (Q16.16)
  task automatic load_box(int h);
    send_plane(4'd0, 18'sh10000, 18'sd0, 18'sd0, 32'(-h));
    send_plane(4'd1, -18'sh10000, 18'sd0, 18'sd0, 32'(-h));
    send_plane(4'd2, 18'sd0, 18'sh10000, 18'sd0, 32'(-h));
    send_plane(4'd3, 18'sd0, -18'sh10000, 18'sd0, 32'(-h));
    send_plane(4'd4, 18'sd0, 18'sd0, 18'sh10000, 32'(-h));
    send_plane(4'd5, 18'sd0, 18'sd0, -18'sh10000, 32'(-h));
  endtask

  initial begin
    int phase_sz;
    zone_sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: box hull, entry, exit, inside, miss, tangent touch, full-range diagonal
    load_box(5 << 16);
    send_segment(-(10 << 16), 0, 0, 0, 0, 0);
    send_segment(0, 0, 0, 10 << 16, 0, 0);
    send_segment(-(1 << 16), 0, 0, 1 << 16, 0, 0);
    send_segment(-(20 << 16), 20 << 16, 0, 20 << 16, 20 << 16, 0);
    send_segment(-(10 << 16), 5 << 16, 0, 10 << 16, 5 << 16, 0);
    send_segment(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    drain();
    // No planes, and a count past storage
    write_reg(CFG_PLANE_COUNT, 32'd0);
    send_segment(1, 2, 3, 4, 5, 6);
    drain();
    for (int k = 6; k < 16; k++)
      send_plane(4'(k), 18'sh1ffff, -18'sh20000, 18'sd1, 32'h80000000);
    drain();
    write_reg(CFG_PLANE_COUNT, 32'd31);
    send_segment(0, 0, 0, 1 << 16, 0, 0);
    drain();
    write_reg(CFG_PLANE_COUNT, 32'd6);
    // Sphere with extremes
    write_reg(CFG_ZONE_IS_SPHERE, 32'd1);
    write_reg(CFG_SPHERE_CENTER_X, 32'd0);
    write_reg(CFG_SPHERE_CENTER_Y, 32'd0);
    write_reg(CFG_SPHERE_CENTER_Z, 32'd0);
    write_reg(CFG_SPHERE_RADIUS, 32'h7fffffff);
    send_segment(32'h80000000, 0, 0, 0, 0, 0);
    send_segment(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 0);
    drain();
    write_reg(CFG_SPHERE_RADIUS, 32'd0);
    send_segment(0, 0, 0, 0, 0, 0);
    drain();
    write_reg(CFG_SPHERE_CENTER_X, 32'h80000000);
    write_reg(CFG_SPHERE_CENTER_Y, 32'h7fffffff);
    write_reg(CFG_SPHERE_CENTER_Z, 32'hffffffff);
    write_reg(CFG_SPHERE_RADIUS, 32'hffffffff);
    send_segment(32'h7fffffff, 0, 0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    drain();

    // Random phases alternating sphere and hull settings
    for (int ph = 0; ph < 14; ph++) begin
      phase_sz = 75;
      if (ph % 2 == 0) begin
        write_reg(CFG_ZONE_IS_SPHERE, 32'd1);
        write_reg(CFG_SPHERE_CENTER_X, rand_coord());
        write_reg(CFG_SPHERE_CENTER_Y, rand_coord());
        write_reg(CFG_SPHERE_CENTER_Z, rand_coord());
        write_reg(CFG_SPHERE_RADIUS, $urandom_range(0, 3) == 0 ? $urandom
                                                              : $urandom_range(0, 30 << 16));
        for (int k = 0; k < phase_sz; k++)
          send_segment(rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord());
      end else begin
        int cnt;
        cnt = (ph == 13) ? 16 : (ph == 11 ? 1 : $urandom_range(1, 8));
        write_reg(CFG_ZONE_IS_SPHERE, 32'd0);
        write_reg(CFG_PLANE_COUNT, 32'(cnt));
        // Mostly well-formed hulls: planes pointing outward with negative offset
        for (int k = 0; k < phase_sz; k++) begin
          if (k % 25 == 0)
            for (int p = 0; p < 16; p++) begin
              if ($urandom_range(0, 4) == 0)
                send_plane(4'(p), rand_normal(), rand_normal(), rand_normal(), $urandom);
              else
                send_plane(4'(p), rand_normal(), rand_normal(), rand_normal(),
                           32'(-$signed($urandom_range(1 << 16, 30 << 16))));
            end
          else
            send_segment(rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord());
        end
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d input transfers and %0d results over sphere and hull zones",
             n_inputs, zone_sb.n_results);
    if (zone_sb.errors == 0 && zone_sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
